/* hdl/bdem_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bdem_pkg
// Shared types and constants of the bay deposit expiry monitor.
// ----------------------------------------------------------------------------
package bdem_pkg;

  localparam int DefMaxBays = 8;
  localparam int ResultCap  = 8;

  localparam logic [32:0] DisplayExtra = 33'd59;
  localparam logic [31:0] BeepLimit    = 32'd3;

  localparam logic [3:0] EnabledBaysReset   = 4'd2;
  localparam logic [3:0] MeterPositionReset = 4'd1;

  typedef enum logic [1:0] {
    REG_ENABLED_BAYS   = 2'd0,
    REG_METER_POSITION = 2'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_INIT     = 2'd0,
    ST_PAID     = 2'd1,
    ST_EXCEEDED = 2'd2,
    ST_STANDBY  = 2'd3
  } bay_status_t;

  typedef enum logic {
    SCAN_IDLE = 1'b0,
    SCAN_RUN  = 1'b1
  } scan_state_t;

  // Classified request handed from the front to the back.
  typedef struct packed {
    logic        is_load;
    logic [2:0]  sel;
    logic [31:0] data;    // paid_until on load, now on tick
    logic [3:0]  count;   // bays to scan on tick
    logic [7:0]  occ;     // occupancy per scanned bay
  } cmd_t;

  typedef struct packed {
    logic [2:0]  bay_index;
    logic [1:0]  bay_state;
    logic [32:0] display_seconds;
    logic        led_green;
    logic        expired_event;
    logic        beep;
    logic        refresh;
    logic        take_photo;
    logic        last;
  } result_t;

endpackage
`default_nettype wire

/* hdl/bdem_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bdem_front
// Holds the configuration, classifies requests and queues them (two entries).
// ----------------------------------------------------------------------------
module bdem_front #(
  parameter int MAX_BAYS = bdem_pkg::DefMaxBays
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic          in_action,
  input  wire logic [31:0]   in_now_time,
  input  wire logic          in_occupied_first,
  input  wire logic          in_occupied_second,
  input  wire logic [2:0]    in_bay_select,
  input  wire logic [31:0]   in_paid_until,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [3:0]    cfg_data,
  output logic               q_valid,
  output bdem_pkg::cmd_t     q_cmd,
  input  wire logic          q_pop
);

  localparam int ScanCap = (MAX_BAYS < bdem_pkg::ResultCap) ? MAX_BAYS
                                                             : bdem_pkg::ResultCap;

  logic [3:0]     enabled_r;
  logic [3:0]     meter_pos_r;
  bdem_pkg::cmd_t fifo_r [2];
  logic           wr_ptr_r;
  logic           rd_ptr_r;
  logic [1:0]     fill_r;
  logic [1:0]     fill_nxt;
  bdem_pkg::cmd_t cmd;
  logic           push;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r   <= bdem_pkg::EnabledBaysReset;
      meter_pos_r <= bdem_pkg::MeterPositionReset;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        bdem_pkg::REG_ENABLED_BAYS:   enabled_r   <= cfg_data;
        bdem_pkg::REG_METER_POSITION: meter_pos_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    cmd         = '0;
    cmd.is_load = in_action;
    cmd.sel     = in_bay_select;
    cmd.data    = in_action ? in_paid_until : in_now_time;
    cmd.count   = (32'(enabled_r) > ScanCap) ? 4'(ScanCap) : enabled_r;
    for (int i = 0; i < 8; i++) begin
      if (meter_pos_r == 4'(i + 1)) begin
        cmd.occ[i] = in_occupied_first;
      end else if (meter_pos_r == 4'(i)) begin
        cmd.occ[i] = in_occupied_second;
      end else begin
        cmd.occ[i] = 1'b0;
      end
    end
  end

  assign in_ready = (fill_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (fill_r != 2'd0);
  assign q_cmd    = fifo_r[rd_ptr_r];

  always_comb begin
    fill_nxt = fill_r;
    if (push && !q_pop) begin
      fill_nxt = fill_r + 2'd1;
    end else if (q_pop && !push) begin
      fill_nxt = fill_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      fill_r <= fill_nxt;
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (q_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= cmd;
    end
  end

endmodule
`default_nettype wire

/* hdl/bdem_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bdem_back
// Bay table and scan sequencer: applies loads, walks bays on a tick, one
// bay per cycle while the result slot is free, into a registered result slot.
// ----------------------------------------------------------------------------
module bdem_back #(
  parameter int MAX_BAYS = bdem_pkg::DefMaxBays
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_valid,
  input  bdem_pkg::cmd_t     q_cmd,
  output logic               q_pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output bdem_pkg::result_t  out_res
);

  localparam int IdxW = (MAX_BAYS > 1) ? $clog2(MAX_BAYS) : 1;

  logic [31:0]           end_time_r [MAX_BAYS];
  bdem_pkg::bay_status_t status_r   [MAX_BAYS];

  bdem_pkg::scan_state_t state_r, state_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic [3:0]  count_r, count_nxt;
  logic [31:0] now_r, now_nxt;
  logic [7:0]  occ_r, occ_nxt;
  logic        beep_r, beep_nxt;
  logic        refresh_r, refresh_nxt;
  logic        photo_r, photo_nxt;
  logic        out_valid_r, out_valid_nxt;
  bdem_pkg::result_t res_r, res_nxt;

  logic                  et_we;
  logic [IdxW-1:0]       et_addr;
  logic [31:0]           et_wdata;
  logic                  st_we;
  bdem_pkg::bay_status_t st_wdata;

  logic [IdxW-1:0]       rd_addr;
  logic [31:0]           cur_end;
  bdem_pkg::bay_status_t prev;
  bdem_pkg::bay_status_t next_st;
  logic                  paid;
  logic [31:0]           left;
  logic                  expired;
  logic                  slot_free;
  logic                  is_last;

  assign rd_addr   = IdxW'(idx_r);
  assign cur_end   = end_time_r[rd_addr];
  assign prev      = status_r[rd_addr];
  assign paid      = cur_end > now_r;
  assign left      = cur_end - now_r;
  assign slot_free = !out_valid_r || out_ready;
  assign is_last   = ({1'b0, idx_r} == (count_r - 4'd1));

  always_comb begin
    expired = 1'b0;
    if (paid) begin
      next_st = bdem_pkg::ST_PAID;
    end else if (occ_r[idx_r]) begin
      next_st = bdem_pkg::ST_EXCEEDED;
      expired = (prev != bdem_pkg::ST_EXCEEDED);
    end else begin
      next_st = bdem_pkg::ST_STANDBY;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    count_nxt     = count_r;
    now_nxt       = now_r;
    occ_nxt       = occ_r;
    beep_nxt      = beep_r;
    refresh_nxt   = refresh_r;
    photo_nxt     = photo_r;
    out_valid_nxt = out_valid_r && !out_ready;
    res_nxt       = res_r;
    q_pop         = 1'b0;
    et_we         = 1'b0;
    et_addr       = rd_addr;
    et_wdata      = 32'd0;
    st_we         = 1'b0;
    st_wdata      = next_st;
    unique case (state_r)
      bdem_pkg::SCAN_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_cmd.is_load) begin
            et_we    = (32'(q_cmd.sel) < MAX_BAYS);
            et_addr  = IdxW'(q_cmd.sel);
            et_wdata = q_cmd.data;
          end else if (q_cmd.count != 4'd0) begin
            state_nxt   = bdem_pkg::SCAN_RUN;
            idx_nxt     = 3'd0;
            count_nxt   = q_cmd.count;
            now_nxt     = q_cmd.data;
            occ_nxt     = q_cmd.occ;
            beep_nxt    = 1'b0;
            refresh_nxt = 1'b0;
            photo_nxt   = 1'b0;
          end
        end
      end
      bdem_pkg::SCAN_RUN: begin
        if (slot_free) begin
          et_we = !paid;
          st_we = 1'b1;
          beep_nxt    = beep_r || (paid && (left < bdem_pkg::BeepLimit));
          refresh_nxt = refresh_r || ((prev != bdem_pkg::ST_INIT) && (prev != next_st));
          photo_nxt   = photo_r || expired;
          res_nxt.bay_index       = idx_r;
          res_nxt.bay_state       = next_st;
          res_nxt.display_seconds = paid ? ({1'b0, left} + bdem_pkg::DisplayExtra) : 33'd0;
          res_nxt.led_green       = paid;
          res_nxt.expired_event   = expired;
          res_nxt.beep            = is_last && beep_nxt;
          res_nxt.refresh         = is_last && refresh_nxt;
          res_nxt.take_photo      = is_last && photo_nxt;
          res_nxt.last            = is_last;
          out_valid_nxt = 1'b1;
          idx_nxt       = idx_r + 3'd1;
          if (is_last) begin
            state_nxt = bdem_pkg::SCAN_IDLE;
          end
        end
      end
      default: state_nxt = bdem_pkg::SCAN_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bdem_pkg::SCAN_IDLE;
      out_valid_r <= 1'b0;
      idx_r       <= 3'd0;
      count_r     <= 4'd0;
      beep_r      <= 1'b0;
      refresh_r   <= 1'b0;
      photo_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
      count_r     <= count_nxt;
      beep_r      <= beep_nxt;
      refresh_r   <= refresh_nxt;
      photo_r     <= photo_nxt;
    end
  end

  always_ff @(posedge clk) begin
    now_r <= now_nxt;
    occ_r <= occ_nxt;
    res_r <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_BAYS; i++) begin
        end_time_r[i] <= 32'd0;
        status_r[i]   <= bdem_pkg::ST_INIT;
      end
    end else begin
      if (et_we) begin
        end_time_r[et_addr] <= et_wdata;
      end
      if (st_we) begin
        status_r[rd_addr] <= st_wdata;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

endmodule
`default_nettype wire

/* hdl/bay_deposit_expiry_monitor.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bay_deposit_expiry_monitor
// Tracks paid-until time and status of each parking bay.
//
// Input channel (in_*): a load request writes one bay's end time and gives
// no result; a tick request carries the time and two occupancy sensor bits
// and gives one result per enabled bay, the final one marked by out_last.
// Config channel (cfg_*): index 0 enabled bays, index 1 meter position;
// always ready; the user writes it only while the block is idle (unenforced).
// Throughput: one bay per cycle from the scan sequencer while the receiver
// keeps out_ready high. A two-entry request queue accepts further requests
// while a scan is running.
// Reset (rst_n low, synchronous): end times cleared, all bays to init,
// registers to 2 enabled bays and meter position 1, queue emptied.
// Receiver stall: the result register holds while out_ready is low and the
// scan waits; requests queue until the queue is full, then in_ready drops.
// ----------------------------------------------------------------------------
module bay_deposit_expiry_monitor #(
  parameter int MAX_BAYS = bdem_pkg::DefMaxBays
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_action,
  input  wire logic [31:0] in_now_time,
  input  wire logic        in_occupied_first,
  input  wire logic        in_occupied_second,
  input  wire logic [2:0]  in_bay_select,
  input  wire logic [31:0] in_paid_until,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_bay_index,
  output logic [1:0]       out_bay_state,
  output logic [32:0]      out_display_seconds,
  output logic             out_led_green,
  output logic             out_expired_event,
  output logic             out_beep,
  output logic             out_refresh,
  output logic             out_take_photo,
  output logic             out_last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [3:0]  cfg_data
);

  logic              q_valid;
  logic              q_pop;
  bdem_pkg::cmd_t    q_cmd;
  bdem_pkg::result_t res;

  bdem_front #(
    .MAX_BAYS (MAX_BAYS)
  ) u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_action          (in_action),
    .in_now_time        (in_now_time),
    .in_occupied_first  (in_occupied_first),
    .in_occupied_second (in_occupied_second),
    .in_bay_select      (in_bay_select),
    .in_paid_until      (in_paid_until),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .q_valid            (q_valid),
    .q_cmd              (q_cmd),
    .q_pop              (q_pop)
  );

  bdem_back #(
    .MAX_BAYS (MAX_BAYS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res)
  );

  assign out_bay_index       = res.bay_index;
  assign out_bay_state       = res.bay_state;
  assign out_display_seconds = res.display_seconds;
  assign out_led_green       = res.led_green;
  assign out_expired_event   = res.expired_event;
  assign out_beep            = res.beep;
  assign out_refresh         = res.refresh;
  assign out_take_photo      = res.take_photo;
  assign out_last            = res.last;

endmodule
`default_nettype wire
